### sv/sgcd_pkg.sv
// sgcd_pkg: shared types and constants for the sequence gcd accumulator
// no dependencies
`timescale 1ns / 1ps

package sgcd_pkg;

	// fixed widths of the channel fields
	localparam int VALUE_W  = 31;
	localparam int RESULT_W = 31;

	// command kinds passed from front to back
	typedef logic [0:0] op_t;
	localparam op_t OP_FOLD = 1'b0;
	localparam op_t OP_LOAD = 1'b1;

	typedef struct packed {
		op_t  op;
		logic emit;
	} ctl_t;

	localparam int CTL_W = $bits(ctl_t);

endpackage

### sv/sgcd_in_if.sv
// sgcd_in_if: input channel, one sequence element per beat
// depends on sgcd_pkg
`timescale 1ns / 1ps

interface sgcd_in_if;
	logic                         valid;
	logic                         ready;
	logic [sgcd_pkg::VALUE_W-1:0] value;
	logic                         is_first;
	logic                         is_last;

	modport source (output valid, value, is_first, is_last, input ready);
	modport sink (input valid, value, is_first, is_last, output ready);
endinterface

### sv/sgcd_out_if.sv
// sgcd_out_if: result channel, one gcd per beat
// depends on sgcd_pkg
`timescale 1ns / 1ps

interface sgcd_out_if;
	logic                          valid;
	logic                          ready;
	logic [sgcd_pkg::RESULT_W-1:0] gcd_result;

	modport source (output valid, gcd_result, input ready);
	modport sink (input valid, gcd_result, output ready);
endinterface

### sv/sgcd_front.sv
// sgcd_front: accepts input beats, trims the element and classifies it
// depends on sgcd_pkg and sgcd_in_if
`timescale 1ns / 1ps

module sgcd_front #(
	parameter int DATA_WIDTH = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	sgcd_in_if.sink                item,
	output logic                   cmd_valid,
	input  logic                   cmd_ready,
	output sgcd_pkg::ctl_t         cmd_ctl,
	output logic [DATA_WIDTH-1:0]  cmd_value
);

	logic                  valid_s1;
	sgcd_pkg::ctl_t        ctl_s1;
	logic [DATA_WIDTH-1:0] value_s1;

	assign item.ready = !valid_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			ctl_s1.op   <= item.is_first ? sgcd_pkg::OP_LOAD : sgcd_pkg::OP_FOLD;
			ctl_s1.emit <= item.is_last;
			value_s1    <= DATA_WIDTH'(item.value);
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd_ctl   = ctl_s1;
	assign cmd_value = value_s1;

endmodule

### sv/sgcd_queue.sv
// sgcd_queue: short command queue between front and back
// no dependencies
`timescale 1ns / 1ps

module sgcd_queue #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/sgcd_back.sv
// sgcd_back: running divisor and iterative binary gcd engine
// depends on sgcd_pkg and sgcd_out_if
`timescale 1ns / 1ps

module sgcd_back #(
	parameter int DATA_WIDTH = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  sgcd_pkg::ctl_t        cmd_ctl,
	input  logic [DATA_WIDTH-1:0] cmd_value,
	sgcd_out_if.source            result
);

	localparam int KW = $clog2(DATA_WIDTH + 1);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_RUN  = 1'b1;

	logic [0:0]            state_q;
	logic [DATA_WIDTH-1:0] running_q;
	logic [DATA_WIDTH-1:0] a_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic [KW-1:0]         k_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic [63:0]           res_wide;

	logic                  slot_free;
	logic                  cmd_pop;
	logic                  run_done;
	logic                  run_fin;
	logic [DATA_WIDTH-1:0] run_gcd;
	logic                  emit_now;
	logic [DATA_WIDTH-1:0] emit_val;

	assign slot_free = !out_valid_q || result.ready;
	assign cmd_ready = (state_q == ST_IDLE) && slot_free;
	assign cmd_pop   = cmd_valid && cmd_ready;

	assign run_done = (a_q == '0) || (b_q == '0);
	assign run_gcd  = ((a_q == '0) ? b_q : a_q) << k_q;
	assign run_fin  = (state_q == ST_RUN) && run_done && (!last_q || slot_free);

	always_comb begin
		emit_now = 1'b0;
		emit_val = run_gcd;
		if (run_fin && last_q) begin
			emit_now = 1'b1;
		end else if (cmd_pop && cmd_ctl.op == sgcd_pkg::OP_LOAD && cmd_ctl.emit) begin
			emit_now = 1'b1;
			emit_val = cmd_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd_ctl.op == sgcd_pkg::OP_LOAD) begin
							running_q <= cmd_ctl.emit ? '0 : cmd_value;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (run_fin) begin
						state_q   <= ST_IDLE;
						running_q <= last_q ? '0 : run_gcd;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operands load while idle; binary gcd step: strip shared twos, strip lone twos, subtract odd from odd
	always_ff @(posedge clk) begin
		if (emit_now) begin
			res_q <= emit_val;
		end
		if (state_q == ST_IDLE) begin
			a_q    <= running_q;
			b_q    <= cmd_value;
			k_q    <= '0;
			last_q <= cmd_ctl.emit;
		end else if (!run_done) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end
	end

	assign res_wide          = 64'(res_q);
	assign result.valid      = out_valid_q;
	assign result.gcd_result = res_wide[sgcd_pkg::RESULT_W-1:0];

	a_shift_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q <= KW'(DATA_WIDTH)))
		else $error("gcd shared shift count out of range");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_now |=> (running_q == '0))
		else $error("running divisor not cleared after a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !emit_now)
		else $error("pending result overwritten");

	a_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && $past(state_q == ST_RUN) && $past(!run_done)) |->
		((DATA_WIDTH + 1)'(a_q) + (DATA_WIDTH + 1)'(b_q) <
		 $past((DATA_WIDTH + 1)'(a_q) + (DATA_WIDTH + 1)'(b_q))))
		else $error("gcd step made no progress");

endmodule

### sv/sequence_gcd_accumulator_core.sv
// an item flagged first and last passes the front stage, the command queue and the result register unchanged
// fold items add a run of binary gcd steps (shift or subtract) in the back
// the back takes no new element during a gcd run; the single gcd engine in the back sets the rate
// a 2-entry command queue lets the input side keep taking beats during a run until it is full
// reset: asynchronous, clears the running divisor, queue and result valid
`timescale 1ns / 1ps

module sequence_gcd_accumulator_core #(
	parameter int DATA_WIDTH = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	sgcd_in_if.sink    item,
	sgcd_out_if.source result
);

	localparam int QW = DATA_WIDTH + sgcd_pkg::CTL_W;

	logic                  f_valid;
	logic                  f_ready;
	sgcd_pkg::ctl_t        f_ctl;
	logic [DATA_WIDTH-1:0] f_value;
	logic                  b_valid;
	logic                  b_ready;
	logic [QW-1:0]         b_data;
	sgcd_pkg::ctl_t        b_ctl;
	logic [DATA_WIDTH-1:0] b_value;

	sgcd_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd_ctl   (f_ctl),
		.cmd_value (f_value)
	);

	sgcd_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_ctl, f_value}),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	assign b_ctl   = b_data[QW-1:DATA_WIDTH];
	assign b_value = b_data[DATA_WIDTH-1:0];

	sgcd_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (b_valid),
		.cmd_ready (b_ready),
		.cmd_ctl   (b_ctl),
		.cmd_value (b_value),
		.result    (result)
	);

endmodule
